// ----- src/gn2d_pkg.sv -----
// gn2d_pkg: shared constants and helpers for the 2D gradient noise core.
// Depends on nothing.
package gn2d_pkg;

	localparam int COORD_W = 24;
	localparam int NOISE_W = 16;
	localparam int PHASE_W = 16;
	localparam int TRIG_W  = 16;   // signed Q1.14 sine/cosine

	localparam logic [31:0] HASH_K1 = 32'd3284157443;
	localparam logic [31:0] HASH_K2 = 32'd1911520717;
	localparam logic [31:0] HASH_K3 = 32'd2048419325;

	// sin(pi/2 * z) ~ z*(A - z^2*(B - z^2*C)), Q2.30
	localparam logic [30:0] SIN_A = 31'd1686629713;
	localparam logic [29:0] SIN_B = 30'd688904866;
	localparam logic [26:0] SIN_C = 27'd76016977;

	localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;

	localparam int HASH_LAT   = 3;
	localparam int SINE_LAT   = 4;
	localparam int DOT_LAT    = 2;
	localparam int CORNER_LAT = HASH_LAT + SINE_LAT + DOT_LAT;
	localparam int SMOOTH_LAT = 3;
	localparam int BLEND_LAT  = 4;

	function automatic logic [31:0] rot16(input logic [31:0] v);
		rot16 = {v[15:0], v[31:16]};
	endfunction

endpackage

// ----- src/gn2d_sine.sv -----
// gn2d_sine: four-stage polynomial sine over a 16-bit phase, Q1.14 result.
// Depends on gn2d_pkg.
module gn2d_sine import gn2d_pkg::*; (
	input  logic                     clk,
	input  logic [PHASE_W-1:0]       phase,
	output logic signed [TRIG_W-1:0] sin_q14
);

	logic [1:0]  quarter;
	logic [14:0] z;
	logic [29:0] zz;

	logic [14:0] z_s1, z_s2, z_s3;
	logic [30:0] z2_s1, z2_s2;
	logic        neg_s1, neg_s2, neg_s3;
	logic [27:0] t1_s2;
	logic [30:0] t2_s3;

	logic [57:0] m2;
	logic [29:0] u3;
	logic [60:0] m3;
	logic [30:0] u4;
	logic [45:0] m4;
	logic [15:0] t3;

	assign quarter = phase[15:14];
	// mirror odd quarters
	assign z  = quarter[0] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
	assign zz = z * z;

	assign m2 = SIN_C * z2_s1;
	assign u3 = SIN_B - {2'b00, t1_s2};
	assign m3 = u3 * z2_s2;
	assign u4 = SIN_A - t2_s3;
	assign m4 = u4 * z_s3;
	assign t3 = m4[45:30];

	always_ff @(posedge clk) begin
		z_s1   <= z;
		z2_s1  <= {zz[28:0], 2'b00};
		neg_s1 <= quarter[1];

		t1_s2  <= m2[57:30];
		z2_s2  <= z2_s1;
		z_s2   <= z_s1;
		neg_s2 <= neg_s1;

		t2_s3  <= m3[60:30];
		z_s3   <= z_s2;
		neg_s3 <= neg_s2;

		sin_q14 <= neg_s3 ? -$signed(t3) : $signed(t3);
	end

endmodule

// ----- src/gn2d_corner.sv -----
// gn2d_corner: corner hash, gradient lookup by sine/cosine and dot product.
// Depends on gn2d_pkg and gn2d_sine.
module gn2d_corner import gn2d_pkg::*; #(
	parameter int ANGLE_BITS = 10,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic [31:0]                  cx,
	input  logic [31:0]                  cy,
	input  logic signed [FRAC_BITS:0]    dx,
	input  logic signed [FRAC_BITS:0]    dy,
	output logic signed [FRAC_BITS+16:0] dot
);

	localparam int DLY = HASH_LAT + SINE_LAT;

	logic [31:0] a_s1, cy_s1, a_s2, b_s2, a_s3;
	logic [ANGLE_BITS-1:0] idx;
	logic [PHASE_W-1:0]    ph_sin, ph_cos;
	logic signed [TRIG_W-1:0] sin_v, cos_v;

	logic signed [FRAC_BITS:0] dx_dly_q [DLY];
	logic signed [FRAC_BITS:0] dy_dly_q [DLY];
	logic signed [FRAC_BITS+16:0] px_s8, py_s8;

	// multiply-xor-rotate hash, wrapping
	always_ff @(posedge clk) begin
		a_s1  <= cx * HASH_K1;
		cy_s1 <= cy;
		b_s2  <= (cy_s1 ^ rot16(a_s1)) * HASH_K2;
		a_s2  <= a_s1;
		a_s3  <= (a_s2 ^ rot16(b_s2)) * HASH_K3;
	end

	assign idx    = a_s3[31 -: ANGLE_BITS];
	assign ph_sin = PHASE_W'(idx) << (PHASE_W - ANGLE_BITS);
	assign ph_cos = ph_sin + QUARTER_TURN;

	gn2d_sine u_sin (.clk(clk), .phase(ph_sin), .sin_q14(sin_v));
	gn2d_sine u_cos (.clk(clk), .phase(ph_cos), .sin_q14(cos_v));

	always_ff @(posedge clk) begin
		dx_dly_q[0] <= dx;
		dy_dly_q[0] <= dy;
		for (int i = 1; i < DLY; i++) begin
			dx_dly_q[i] <= dx_dly_q[i-1];
			dy_dly_q[i] <= dy_dly_q[i-1];
		end
		px_s8 <= dx_dly_q[DLY-1] * sin_v;
		py_s8 <= dy_dly_q[DLY-1] * cos_v;
		dot   <= px_s8 + py_s8;
	end

endmodule

// ----- src/gn2d_smooth.sv -----
// gn2d_smooth: three-stage smoothstep 3w^2-2w^3 of a fraction, Q16 result.
// Depends on gn2d_pkg.
module gn2d_smooth import gn2d_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic [FRAC_BITS-1:0] w,
	output logic [16:0]          s_q16
);

	localparam int SW   = 3*FRAC_BITS + 2;
	localparam int WIDE = 3*FRAC_BITS + 18;
	localparam int SH_R = (3*FRAC_BITS >= 16) ? 3*FRAC_BITS - 16 : 0;
	localparam int SH_L = (3*FRAC_BITS >= 16) ? 0 : 16 - 3*FRAC_BITS;

	logic [2*FRAC_BITS-1:0] ww_s1;
	logic [FRAC_BITS+1:0]   k_s1;
	logic [SW-1:0]          s_s2;
	logic [WIDE-1:0]        wide, scaled;

	assign wide   = WIDE'(s_s2);
	assign scaled = (wide >> SH_R) << SH_L;

	always_ff @(posedge clk) begin
		ww_s1 <= w * w;
		k_s1  <= ((FRAC_BITS+2)'(3) << FRAC_BITS) - {1'b0, w, 1'b0};
		s_s2  <= k_s1 * ww_s1;
		s_q16 <= scaled[16:0];
	end

endmodule

// ----- src/gradient_noise_2d_core.sv -----
// gradient_noise_2d_core: 2D Perlin gradient noise, one point per cycle.
// Depends on gn2d_pkg, gn2d_corner, gn2d_smooth.
// Pipeline: input register, then the corner stages, then the blend stages, from start to done.
// Throughput: one item per cycle; busy is always low, nothing in the pipe stalls.
// Reset: arst_n clears the valid pipe only; payload registers are not reset.
// The done strobe lasts one cycle and cannot be held off by the receiver.
module gradient_noise_2d_core import gn2d_pkg::*; #(
	parameter int ANGLE_BITS = 10,
	parameter int FRAC_BITS  = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [COORD_W-1:0]        coord_x,
	input  logic [COORD_W-1:0]        coord_y,
	output logic                      done,
	output logic signed [NOISE_W-1:0] noise_value
);

	localparam int N_W     = FRAC_BITS + 17;        // corner dot width
	localparam int P_W     = N_W + 19;              // blend product width
	localparam int V_W     = N_W - FRAC_BITS;       // blended value after descale
	localparam int PIPE    = 1 + CORNER_LAT + BLEND_LAT;
	localparam int SX_DLY  = CORNER_LAT - SMOOTH_LAT;
	localparam int SY_DLY  = SX_DLY + 2;

	// ---- input stage -----------------------------------------------------
	logic [COORD_W-1:0] x_s1, y_s1;
	logic [PIPE-1:0]    vld_q;   // valid bit per stage, bit 0 = stage 1

	assign busy = 1'b0;

	always_ff @(posedge clk) begin
		if (start) begin
			x_s1 <= coord_x;
			y_s1 <= coord_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE-2:0], start};
		end
	end

	assign done = vld_q[PIPE-1];

	// ---- lattice cell and offsets ----------------------------------------
	logic [31:0] x0, y0, x1, y1;
	logic [FRAC_BITS-1:0] fx, fy;
	logic signed [FRAC_BITS:0] dx0, dx1, dy0, dy1;

	assign x0 = 32'(x_s1 >> FRAC_BITS);
	assign y0 = 32'(y_s1 >> FRAC_BITS);
	assign x1 = x0 + 32'd1;   // never wraps: integer part is at most COORD_W - FRAC_BITS (16) bits
	assign y1 = y0 + 32'd1;
	assign fx = x_s1[FRAC_BITS-1:0];
	assign fy = y_s1[FRAC_BITS-1:0];
	// offset from the near corner is f, from the far corner f - 1
	assign dx0 = $signed({1'b0, fx});
	assign dx1 = $signed({1'b1, fx});
	assign dy0 = $signed({1'b0, fy});
	assign dy1 = $signed({1'b1, fy});

	// ---- four corners, in parallel ---------------------------------------
	logic signed [N_W-1:0] n00, n10, n01, n11;

	gn2d_corner #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c00 (
		.clk(clk), .cx(x0), .cy(y0), .dx(dx0), .dy(dy0), .dot(n00));
	gn2d_corner #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c10 (
		.clk(clk), .cx(x1), .cy(y0), .dx(dx1), .dy(dy0), .dot(n10));
	gn2d_corner #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c01 (
		.clk(clk), .cx(x0), .cy(y1), .dx(dx0), .dy(dy1), .dot(n01));
	gn2d_corner #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c11 (
		.clk(clk), .cx(x1), .cy(y1), .dx(dx1), .dy(dy1), .dot(n11));

	// ---- fade weights, delayed to meet the corner results ----------------
	logic [16:0] sx, sy;
	logic [16:0] sx_dly_q [SX_DLY];
	logic [16:0] sy_dly_q [SY_DLY];

	gn2d_smooth #(.FRAC_BITS(FRAC_BITS)) u_sx (.clk(clk), .w(fx), .s_q16(sx));
	gn2d_smooth #(.FRAC_BITS(FRAC_BITS)) u_sy (.clk(clk), .w(fy), .s_q16(sy));

	always_ff @(posedge clk) begin
		sx_dly_q[0] <= sx;
		for (int i = 1; i < SX_DLY; i++) sx_dly_q[i] <= sx_dly_q[i-1];
		sy_dly_q[0] <= sy;
		for (int i = 1; i < SY_DLY; i++) sy_dly_q[i] <= sy_dly_q[i-1];
	end

	// ---- blend along x (two stages), then along y (two stages) -----------
	logic signed [N_W:0]   dtop, dbot, dvert;
	logic signed [P_W-1:0] ptop_s11, pbot_s11, pv_s13;
	logic signed [N_W-1:0] n00_s11, n01_s11;
	logic signed [N_W-1:0] top_s12, bot_s12, top_s13;
	logic signed [N_W:0]   vsum;
	logic signed [N_W:0]   vdiv;
	logic signed [V_W-1:0] v;

	assign dtop  = (N_W+1)'(n10) - (N_W+1)'(n00);
	assign dbot  = (N_W+1)'(n11) - (N_W+1)'(n01);
	assign dvert = (N_W+1)'(bot_s12) - (N_W+1)'(top_s12);

	// floor of product / 2^16 is an arithmetic shift
	assign vsum = (N_W+1)'(top_s13 + (pv_s13 >>> 16));
	assign vdiv = vsum >>> FRAC_BITS;
	assign v    = vdiv[V_W-1:0];

	always_ff @(posedge clk) begin
		ptop_s11 <= dtop * $signed({1'b0, sx_dly_q[SX_DLY-1]});
		pbot_s11 <= dbot * $signed({1'b0, sx_dly_q[SX_DLY-1]});
		n00_s11  <= n00;
		n01_s11  <= n01;

		top_s12 <= N_W'(n00_s11 + (ptop_s11 >>> 16));
		bot_s12 <= N_W'(n01_s11 + (pbot_s11 >>> 16));

		pv_s13  <= dvert * $signed({1'b0, sy_dly_q[SY_DLY-1]});
		top_s13 <= top_s12;

		// saturate to the 16-bit result
		if (v > $signed(V_W'(32767)))
			noise_value <= 16'sd32767;
		else if (v < -$signed(V_W'(32768)))
			noise_value <= -16'sd32768;
		else
			noise_value <= v[NOISE_W-1:0];
	end

endmodule
